[hw/rtl/node_presence_table_with_aging_defines.svh]
// Assertion helpers used by the checker file npt_checker.sv.
`ifndef NODE_PRESENCE_TABLE_WITH_AGING_DEFINES_SVH
`define NODE_PRESENCE_TABLE_WITH_AGING_DEFINES_SVH

// Same-cycle implication.
`define NPT_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication.
`define NPT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[hw/rtl/npt_pkg.sv]
package npt_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int KEY_BITS      = 64;

   localparam int IDX_W      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W      = $clog2(TABLE_ENTRIES + 1);
   localparam int KEY_PORT_W = 64;
   localparam int OUT_IDX_W  = 4;
   localparam int TRACK_W    = 5;

   localparam logic [31:0] LIMIT_RESET = 32'd60000;

   localparam logic [1:0] OP_REPORT = 2'd0;
   localparam logic [1:0] OP_SWEEP  = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   typedef enum logic [2:0] {
      KIND_UPDATED      = 3'd0,
      KIND_BACK_ONLINE  = 3'd1,
      KIND_REGISTERED   = 3'd2,
      KIND_TABLE_FULL   = 3'd3,
      KIND_WENT_OFFLINE = 3'd4,
      KIND_SWEEP_DONE   = 3'd5,
      KIND_READ_OK      = 3'd6,
      KIND_READ_EMPTY   = 3'd7
   } kind_type;

   localparam logic [1:0] ENT_UNKNOWN = 2'd0;
   localparam logic [1:0] ENT_ONLINE  = 2'd1;
   localparam logic [1:0] ENT_OFFLINE = 2'd2;

   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [31:0]         seen;
      logic signed [8:0]   rssi;
      logic [7:0]          batt;
      logic [1:0]          state;
      logic [31:0]         frames;
      logic [31:0]         hbs;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_FETCH = 4'b0100,
      ST_EMIT  = 4'b1000
   } seq_state_type;

endpackage

[hw/rtl/npt_ram.sv]
module npt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/node_presence_table_with_aging.sv]
// A report or sweep walks the table through one RAM read port, one entry per cycle while no
// expired entry's result is being emitted and rsp_stall does not hold the output; a report
// hit ends the walk early. A read fetches its entry from the RAM before it answers; an empty
// read answers with no RAM read. One item at a time; req_stall is high while an item is in work.
// Reset (synchronous, active high) clears the used bits, node count and sequencer, and
// loads the offline limit with 60000 ms. Table contents are not cleared.
module node_presence_table_with_aging (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_operation,
   input  logic [npt_pkg::KEY_PORT_W-1:0] req_node_key,
   input  logic signed [8:0]         req_signal_strength,
   input  logic [7:0]                req_battery_level,
   input  logic                      req_is_heartbeat,
   input  logic [31:0]               req_now_ms,
   input  logic [3:0]                req_read_index,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [2:0]                rsp_result_kind,
   output logic [3:0]                rsp_entry_index,
   output logic [npt_pkg::KEY_PORT_W-1:0] rsp_entry_key,
   output logic signed [8:0]         rsp_entry_rssi,
   output logic [7:0]                rsp_entry_battery,
   output logic [31:0]               rsp_entry_frames,
   output logic [31:0]               rsp_entry_heartbeats,
   output logic [1:0]                rsp_entry_state,
   output logic [31:0]               rsp_entry_last_seen,
   output logic [4:0]                rsp_nodes_tracked,
   output logic                      rsp_last_of_run,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [31:0]               csr_offline_limit_ms
);

   import npt_pkg::*;

   seq_state_type             state_ff, state_in;
   logic [CNT_W-1:0]          idx_ff, idx_in;
   logic                      rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]          rd_idx_ff, rd_idx_in;
   logic                      free_vld_ff, free_vld_in;
   logic [IDX_W-1:0]          free_idx_ff, free_idx_in;
   logic [TABLE_ENTRIES-1:0]  used_ff, used_in;
   logic [CNT_W-1:0]          total_ff, total_in;
   logic [31:0]               limit_ff, limit_in;

   logic [1:0]                op_ff, op_in;
   logic [KEY_BITS-1:0]       key_ff, key_in;
   logic signed [8:0]         rssi_ff, rssi_in;
   logic [7:0]                batt_ff, batt_in;
   logic                      hb_ff, hb_in;
   logic [31:0]               now_ff, now_in;

   entry_type                 cur_ff, cur_in;
   logic [OUT_IDX_W-1:0]      cur_idx_ff, cur_idx_in;
   kind_type                  kind_ff, kind_in;
   logic                      last_ff, last_in;

   logic                      rsp_valid_ff;
   logic [2:0]                rsp_kind_ff;
   logic [3:0]                rsp_index_ff;
   logic [KEY_PORT_W-1:0]     rsp_key_ff;
   logic signed [8:0]         rsp_rssi_ff;
   logic [7:0]                rsp_batt_ff;
   logic [31:0]               rsp_frames_ff;
   logic [31:0]               rsp_hbs_ff;
   logic [1:0]                rsp_state_ff;
   logic [31:0]               rsp_seen_ff;
   logic [4:0]                rsp_tracked_ff;
   logic                      rsp_last_ff;

   logic                      ram_wr_en;
   logic [IDX_W-1:0]          ram_wr_addr;
   logic [ENTRY_W-1:0]        ram_wr_data;
   logic                      ram_rd_en;
   logic [IDX_W-1:0]          ram_rd_addr;
   logic [ENTRY_W-1:0]        ram_rd_data;

   entry_type                 rd_entry;
   entry_type                 hit_upd;
   entry_type                 off_upd;
   entry_type                 new_ent;
   logic [31:0]               age;
   logic                      used_r;
   logic                      hit;
   logic                      expire;
   logic                      read_ok;
   logic                      out_free;
   logic                      out_load;

   npt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_entry = ram_rd_data;

   // Match unit: key compare for reports, modular age compare for sweeps.
   assign used_r = used_ff[rd_idx_ff];
   assign age    = now_ff - rd_entry.seen;
   assign hit    = rd_vld_ff && used_r && (op_ff == OP_REPORT) && (rd_entry.key == key_ff);
   assign expire = rd_vld_ff && used_r && (op_ff == OP_SWEEP)
                   && (rd_entry.state != ENT_OFFLINE) && (age >= limit_ff);

   always_comb begin
      hit_upd        = rd_entry;
      hit_upd.seen   = now_ff;
      hit_upd.rssi   = rssi_ff;
      hit_upd.batt   = batt_ff;
      hit_upd.frames = rd_entry.frames + 32'd1;
      hit_upd.hbs    = rd_entry.hbs + 32'(hb_ff);
      hit_upd.state  = ENT_ONLINE;

      off_upd        = rd_entry;
      off_upd.state  = ENT_OFFLINE;

      new_ent.key    = key_ff;
      new_ent.seen   = now_ff;
      new_ent.rssi   = rssi_ff;
      new_ent.batt   = batt_ff;
      new_ent.state  = ENT_ONLINE;
      new_ent.frames = 32'd1;
      new_ent.hbs    = 32'(hb_ff);
   end

   assign read_ok  = (32'(req_read_index) < TABLE_ENTRIES)
                     && used_ff[IDX_W'(req_read_index)];
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_load = (state_ff == ST_EMIT) && out_free;

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      rd_vld_in   = 1'b0;
      rd_idx_in   = rd_idx_ff;
      free_vld_in = free_vld_ff;
      free_idx_in = free_idx_ff;
      used_in     = used_ff;
      total_in    = total_ff;
      limit_in    = csr_valid ? csr_offline_limit_ms : limit_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      rssi_in     = rssi_ff;
      batt_in     = batt_ff;
      hb_in       = hb_ff;
      now_in      = now_ff;
      cur_in      = cur_ff;
      cur_idx_in  = cur_idx_ff;
      kind_in     = kind_ff;
      last_in     = last_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff[IDX_W-1:0];
      ram_wr_en   = 1'b0;
      ram_wr_addr = rd_idx_ff;
      ram_wr_data = hit_upd;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in   = req_operation;
               key_in  = req_node_key[KEY_BITS-1:0];
               rssi_in = req_signal_strength;
               batt_in = req_battery_level;
               hb_in   = req_is_heartbeat;
               now_in  = req_now_ms;
               if (req_operation == OP_REPORT || req_operation == OP_SWEEP) begin
                  idx_in      = '0;
                  free_vld_in = 1'b0;
                  state_in    = ST_SCAN;
               end else if (req_operation == OP_READ) begin
                  cur_idx_in = req_read_index;
                  last_in    = 1'b1;
                  if (read_ok) begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = IDX_W'(req_read_index);
                     kind_in     = KIND_READ_OK;
                     state_in    = ST_FETCH;
                  end else begin
                     cur_in   = '0;
                     kind_in  = KIND_READ_EMPTY;
                     state_in = ST_EMIT;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (rd_vld_ff && !used_r && !free_vld_ff) begin
               free_vld_in = 1'b1;
               free_idx_in = rd_idx_ff;
            end
            if (hit) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = hit_upd;
               cur_in      = hit_upd;
               cur_idx_in  = OUT_IDX_W'(rd_idx_ff);
               kind_in     = (rd_entry.state == ENT_ONLINE) ? KIND_UPDATED
                                                             : KIND_BACK_ONLINE;
               last_in     = 1'b1;
               state_in    = ST_EMIT;
            end else if (expire) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = off_upd;
               cur_in      = off_upd;
               cur_idx_in  = OUT_IDX_W'(rd_idx_ff);
               kind_in     = KIND_WENT_OFFLINE;
               last_in     = 1'b0;
               state_in    = ST_EMIT;
            end else if (idx_ff < CNT_W'(TABLE_ENTRIES)) begin
               ram_rd_en = 1'b1;
               rd_vld_in = 1'b1;
               rd_idx_in = idx_ff[IDX_W-1:0];
               idx_in    = idx_ff + CNT_W'(1);
            end else if (!rd_vld_ff) begin
               // walk finished: close the item
               last_in  = 1'b1;
               state_in = ST_EMIT;
               if (op_ff == OP_REPORT) begin
                  if (free_vld_ff) begin
                     ram_wr_en            = 1'b1;
                     ram_wr_addr          = free_idx_ff;
                     ram_wr_data          = new_ent;
                     used_in[free_idx_ff] = 1'b1;
                     total_in             = total_ff + CNT_W'(1);
                     cur_in               = new_ent;
                     cur_idx_in           = OUT_IDX_W'(free_idx_ff);
                     kind_in              = KIND_REGISTERED;
                  end else begin
                     cur_in     = '0;
                     cur_in.key = key_ff;
                     cur_idx_in = '0;
                     kind_in    = KIND_TABLE_FULL;
                  end
               end else begin
                  cur_in     = '0;
                  cur_idx_in = '0;
                  kind_in    = KIND_SWEEP_DONE;
               end
            end
         end
         ST_FETCH: begin
            cur_in   = rd_entry;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = last_ff ? ST_IDLE : ST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         used_ff      <= '0;
         total_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_vld_in;
         used_ff   <= used_in;
         total_ff  <= total_in;
         limit_ff  <= limit_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      rd_idx_ff   <= rd_idx_in;
      free_vld_ff <= free_vld_in;
      free_idx_ff <= free_idx_in;
      op_ff       <= op_in;
      key_ff      <= key_in;
      rssi_ff     <= rssi_in;
      batt_ff     <= batt_in;
      hb_ff       <= hb_in;
      now_ff      <= now_in;
      cur_ff      <= cur_in;
      cur_idx_ff  <= cur_idx_in;
      kind_ff     <= kind_in;
      last_ff     <= last_in;
      if (out_load) begin
         rsp_kind_ff    <= kind_ff;
         rsp_index_ff   <= cur_idx_ff;
         rsp_key_ff     <= KEY_PORT_W'(cur_ff.key);
         rsp_rssi_ff    <= cur_ff.rssi;
         rsp_batt_ff    <= cur_ff.batt;
         rsp_frames_ff  <= cur_ff.frames;
         rsp_hbs_ff     <= cur_ff.hbs;
         rsp_state_ff   <= cur_ff.state;
         rsp_seen_ff    <= cur_ff.seen;
         rsp_tracked_ff <= TRACK_W'(total_ff);
         rsp_last_ff    <= last_ff;
      end
   end

   assign req_stall            = (state_ff != ST_IDLE);
   assign csr_ready            = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_result_kind      = rsp_kind_ff;
   assign rsp_entry_index      = rsp_index_ff;
   assign rsp_entry_key        = rsp_key_ff;
   assign rsp_entry_rssi       = rsp_rssi_ff;
   assign rsp_entry_battery    = rsp_batt_ff;
   assign rsp_entry_frames     = rsp_frames_ff;
   assign rsp_entry_heartbeats = rsp_hbs_ff;
   assign rsp_entry_state      = rsp_state_ff;
   assign rsp_entry_last_seen  = rsp_seen_ff;
   assign rsp_nodes_tracked    = rsp_tracked_ff;
   assign rsp_last_of_run      = rsp_last_ff;

endmodule

[hw/rtl/npt_checker.sv]
`include "node_presence_table_with_aging_defines.svh"

module npt_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [1:0] req_operation,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_result_kind,
   input logic [3:0] rsp_entry_index,
   input logic [4:0] rsp_nodes_tracked,
   input logic       rsp_last_of_run
);

   import npt_pkg::*;

   // a real operation keeps the block busy in the following cycle
   `NPT_ASSERT_NEXT(a_busy_after_op, clock, reset, req_valid && !req_stall && (req_operation == OP_REPORT || req_operation == OP_SWEEP || req_operation == OP_READ), req_stall)

   // only an offline result leaves the run open
   `NPT_ASSERT_IMPLY(a_last_flag, clock, reset, rsp_valid, rsp_last_of_run == (rsp_result_kind != KIND_WENT_OFFLINE))

   `NPT_ASSERT_IMPLY(a_tracked_bound, clock, reset, rsp_valid, 32'(rsp_nodes_tracked) <= TABLE_ENTRIES)

   `NPT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_result_kind) && $stable(rsp_entry_index))

endmodule

bind node_presence_table_with_aging npt_checker u_npt_checker (.*);
